// ===== design/sdt_pkg.sv =====
package sdt_pkg;

    // Field widths
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int KEY_W    = MONTH_W + DAY_W;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH      = 64;
    localparam int DEF_RECORDS_PER_DATE = 8;

    // Request codes
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic               action;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  record_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // One table slot: sort key (month, then day) and its record count
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

// ===== design/sorted_date_table.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (action, month, day_of_month)
// out     | output    | out_valid / out_ready| out_data (found, position, record_count, status)
//
// One beat at a time: a new beat is taken only in S_IDLE. Each beat passes S_IDLE,
// then a scan that reads one entry per cycle up to the date's place, then
// S_RESOLVE; an insert then moves the tail one entry per cycle over the single
// write port in S_SHIFT and places the date in S_PLACE; last comes S_DONE. The
// result shows on out_valid at the edge that ends S_DONE. Reset clears the entry
// count; the table memory is not cleared.
// A stalled output holds the sequencer in its done cycle until the register frees.
module sorted_date_table #(
    parameter int TABLE_DEPTH      = sdt_pkg::DEF_TABLE_DEPTH,
    parameter int RECORDS_PER_DATE = sdt_pkg::DEF_RECORDS_PER_DATE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sdt_pkg::out_item_t out_data
);
    import sdt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic          res_valid;
    logic          res_ready;
    out_item_t     res_data;

    logic          out_valid_reg;
    out_item_t     out_data_reg;

    sdt_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sdt_ctrl #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .RECORDS_PER_DATE (RECORDS_PER_DATE),
        .AW               (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a taken beat leaves the sequencer busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // a handed-over result shows on the output next cycle
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> out_valid)
        else $error("result lost at output register");

    // a date that was found always holds at least one record
    a_found_has_records: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.record_count != '0)
        else $error("found date with zero records");

    // full table is only reported for a date that was absent
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |-> !out_data.found
            && out_data.record_count == '0)
        else $error("table full reported on a present date");

endmodule

// ===== design/sdt_ram.sv =====
module sdt_ram #(
    parameter int DEPTH = sdt_pkg::DEF_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  sdt_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output sdt_pkg::entry_t rd_data
);
    import sdt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sdt_ctrl.sv =====
module sdt_ctrl #(
    parameter int TABLE_DEPTH      = sdt_pkg::DEF_TABLE_DEPTH,
    parameter int RECORDS_PER_DATE = sdt_pkg::DEF_RECORDS_PER_DATE,
    parameter int AW               = $clog2(TABLE_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdt_pkg::in_item_t  in_data,
    output logic               res_valid,
    input  logic               res_ready,
    output sdt_pkg::out_item_t res_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output sdt_pkg::entry_t    wr_data,
    output logic [AW-1:0]      rd_addr,
    input  sdt_pkg::entry_t    rd_data
);
    import sdt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0]      FULL_CNT = CW'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] SAT_CNT  = COUNT_W'(RECORDS_PER_DATE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      entry_count_reg, entry_count_next;
    out_item_t          res_reg, res_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic               action_reg, action_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               found_reg, found_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]      rd_idx;
    logic [CW-1:0]      wr_idx;

    // sequencer: scan, resolve, shift tail, place new entry
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        res_next         = res_reg;
        key_next         = key_reg;
        action_next      = action_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        cnt_next         = cnt_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        wr_en            = 1'b0;
        wr_idx           = pos_reg;
        wr_data          = '{key: key_reg, count: COUNT_W'(1)};
        rd_idx           = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_idx   = '0;
                if (in_valid)
                begin
                    key_next    = {in_data.month, in_data.day_of_month};
                    action_next = in_data.action;
                    idx_next    = '0;
                    pos_next    = '0;
                    found_next  = 1'b0;
                    state_next  = (entry_count_reg == '0) ? S_RESOLVE : S_SCAN;
                end
            end

            // rd_data holds entry idx_reg; stop at the first key not below ours
            S_SCAN:
            begin
                rd_idx = idx_reg + CW'(1);
                if (rd_data.key == key_reg)
                begin
                    found_next = 1'b1;
                    cnt_next   = rd_data.count;
                    pos_next   = idx_reg;
                    state_next = S_RESOLVE;
                end
                else if (rd_data.key > key_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = S_RESOLVE;
                end
                else if (idx_reg + CW'(1) == entry_count_reg)
                begin
                    pos_next   = entry_count_reg;
                    state_next = S_RESOLVE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_RESOLVE:
            begin
                rd_idx     = entry_count_reg - CW'(1);
                state_next = S_DONE;
                if (found_reg)
                begin
                    res_next = '{found: 1'b1, position: POS_W'(pos_reg),
                                 record_count: cnt_reg, status: ST_OK};
                    if (action_reg == ACT_ADD)
                    begin
                        if (cnt_reg >= SAT_CNT)
                        begin
                            res_next.status = ST_SATURATED;
                        end
                        else
                        begin
                            wr_en                 = 1'b1;
                            wr_data.count         = cnt_reg + COUNT_W'(1);
                            res_next.record_count = cnt_reg + COUNT_W'(1);
                        end
                    end
                end
                else
                begin
                    res_next = '{found: 1'b0, position: POS_W'(entry_count_reg),
                                 record_count: '0, status: ST_OK};
                    if (action_reg == ACT_ADD)
                    begin
                        if (entry_count_reg == FULL_CNT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else if (pos_reg == entry_count_reg)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            // prime the tail move: read last entry, write one past it
                            idx_next   = entry_count_reg;
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            // rd_data holds entry idx_reg-1; move it to idx_reg
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_idx  = idx_reg;
                wr_data = rd_data;
                rd_idx  = idx_reg - CW'(2);
                if (idx_reg - CW'(1) == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                end
            end

            S_PLACE:
            begin
                wr_en            = 1'b1;
                entry_count_next = entry_count_reg + CW'(1);
                res_next         = '{found: 1'b0, position: POS_W'(pos_reg),
                                     record_count: COUNT_W'(1), status: ST_OK};
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr  = rd_idx[AW-1:0];
    assign wr_addr  = wr_idx[AW-1:0];
    assign res_data = res_reg;

    // control state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            res_reg         <= res_next;
        end
    end

    // working registers of the current beat
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        action_reg <= action_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        cnt_reg    <= cnt_next;
    end

endmodule
